// ----- hdl/psm_pkg.sv -----
// shared types and constants of the pitched sample mixer
package psm_pkg;

    localparam int BYTE_W  = 8;
    localparam int FRAME_W = 8;
    localparam int IDX_W   = 12;
    localparam int SPEED_W = 16;
    localparam int VOL_W   = 9;
    localparam int LEN_W   = 13;
    localparam int ACC_W   = 17;
    localparam int K_W     = 18;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // input commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MIX  = 1'b1;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_SAMPLE_SPEED  = 2'd0;
    localparam logic [1:0] REG_CURRENT_SPEED = 2'd1;
    localparam logic [1:0] REG_VOLUME        = 2'd2;
    localparam logic [1:0] REG_SAMPLE_LENGTH = 2'd3;

    localparam logic [SPEED_W-1:0] RST_SAMPLE_SPEED  = 16'd1;
    localparam logic [SPEED_W-1:0] RST_CURRENT_SPEED = 16'd1;
    localparam logic [VOL_W-1:0]   RST_VOLUME        = 9'd256;
    localparam logic [LEN_W-1:0]   RST_SAMPLE_LENGTH = 13'd4096;

    // second gain stage numerator, over 256
    localparam logic signed [15:0] SCALE_NUM = 16'sd40;

    localparam logic [FRAME_W-1:0] SAT_MAX = 8'h7f;
    localparam logic [FRAME_W-1:0] SAT_MIN = 8'h80;

    typedef struct packed {
        logic [SPEED_W-1:0] sample_speed;
        logic [SPEED_W-1:0] current_speed;
        logic [VOL_W-1:0]   volume;
        logic [LEN_W-1:0]   sample_length;
    } t_cfg;

endpackage

// ----- hdl/psm_if.sv -----
// stream channel interfaces of the pitched sample mixer
interface psm_in_if import psm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [IDX_W-1:0]          load_index;
    logic [BYTE_W-1:0]         sample_byte;
    logic signed [FRAME_W-1:0] mix_in;
    logic                      block_end;

    modport source (
        output valid, command, load_index, sample_byte, mix_in, block_end,
        input  ready
    );
    modport sink (
        input  valid, command, load_index, sample_byte, mix_in, block_end,
        output ready
    );
endinterface

interface psm_out_if import psm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FRAME_W-1:0] mix_out;
    logic                      clipped;
    logic                      block_end_out;

    modport source (
        output valid, mix_out, clipped, block_end_out,
        input  ready
    );
    modport sink (
        input  valid, mix_out, clipped, block_end_out,
        output ready
    );
endinterface

// ----- hdl/psm_cfg.sv -----
// apb configuration registers of the pitched sample mixer
module psm_cfg import psm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (paddr[3:2])
                REG_SAMPLE_SPEED:  n_cfg.sample_speed  = pwdata[SPEED_W-1:0];
                REG_CURRENT_SPEED: n_cfg.current_speed = pwdata[SPEED_W-1:0];
                REG_VOLUME:        n_cfg.volume        = pwdata[VOL_W-1:0];
                REG_SAMPLE_LENGTH: n_cfg.sample_length = pwdata[LEN_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SAMPLE_SPEED:  prdata = PDATA_W'(r_cfg.sample_speed);
            REG_CURRENT_SPEED: prdata = PDATA_W'(r_cfg.current_speed);
            REG_VOLUME:        prdata = PDATA_W'(r_cfg.volume);
            REG_SAMPLE_LENGTH: prdata = PDATA_W'(r_cfg.sample_length);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_speed  <= RST_SAMPLE_SPEED;
            r_cfg.current_speed <= RST_CURRENT_SPEED;
            r_cfg.volume        <= RST_VOLUME;
            r_cfg.sample_length <= RST_SAMPLE_LENGTH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- hdl/psm_store.sv -----
// sample store: one write port, one registered read port
module psm_store import psm_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- hdl/psm_div.sv -----
// shared restoring divider, one quotient bit per cycle
module psm_div import psm_pkg::*; #(
    parameter int NW = 19,
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);

    localparam int CNTW = $clog2(NW + 1);

    logic [CNTW-1:0] r_cnt;
    logic            r_done;
    logic [NW-1:0]   r_quo;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_den;
    logic [DW:0]     w_trial;
    logic [DW:0]     w_diff;
    logic            w_ge;

    assign w_trial = {r_rem, r_quo[NW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNTW'(NW);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - CNTW'(1);
            r_done <= (r_cnt == CNTW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

endmodule

// ----- hdl/pitched_sample_mixer_top.sv -----
// top level of the pitched sample mixer
//
// i_in carries load beats (command 0: write sample_byte at load_index, mark a
// sample present, rewind the play position) and mix beats (command 1: one
// signed destination frame). every mix beat yields one beat on o_out with the
// destination plus the scaled sample byte once a sample is present, saturated to 8 bits, and a clip flag.
// registers sit on the apb port: sample speed, current speed, volume, length.
// a load leaves the sequencer idle, so the next beat can follow at once.
// with a sample present a mix beat steps the sequencer through S_MUL1, S_MUL2,
// S_ACC, S_POS and S_DONE, without one straight to S_DONE; S_DONE registers the frame on o_out.
// when the phase accumulator passes the sample speed, or the position wraps
// more than once, the sequencer also waits in S_DIVK or S_DIVP until the shared
// divider of NW quotient bits is done (NW = max(log2 depth, 18) + 1, 19 at the default depth).
// i_in.ready is high only while the sequencer is idle.
// a finished frame waits in the output register; while o_out stalls the
// sequencer holds its next frame and i_in.ready stays low.
// reset (i_rst_n low, synchronous) clears the play position, accumulator,
// sample-present flag and output valid, and loads the register defaults;
// the sample store is not cleared and must be loaded before it is played.
module pitched_sample_mixer_top import psm_pkg::*; #(
    parameter int SAMPLE_DEPTH = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    psm_in_if.sink             i_in,
    psm_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // widths that follow from the store depth
    localparam int PW  = $clog2(SAMPLE_DEPTH);
    localparam int LW  = $clog2(SAMPLE_DEPTH + 1);
    localparam int NW  = ((PW > K_W) ? PW : K_W) + 1;
    localparam int DVW = (LW > SPEED_W) ? LW : SPEED_W;
    localparam int CW  = (LW > LEN_W) ? LW : LEN_W;
    localparam int XW  = (LW > IDX_W) ? LW : IDX_W;
    localparam int MW  = ((NW > DVW) ? NW : DVW) + 1;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_DIVK = 3'd4;
    localparam logic [2:0] S_POS  = 3'd5;
    localparam logic [2:0] S_DIVP = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    t_cfg w_cfg;

    // control registers
    logic [2:0]         r_state,   n_state;
    logic               r_present, n_present;
    logic [PW-1:0]      r_pos,     n_pos;
    logic [ACC_W-1:0]   r_acc,     n_acc;
    logic               r_ovalid,  n_ovalid;

    // payload registers
    logic [K_W-1:0]            r_num,     n_num;
    logic [K_W-1:0]            r_k,       n_k;
    logic signed [FRAME_W-1:0] r_mix,     n_mix;
    logic                      r_bend,    n_bend;
    logic signed [17:0]        r_p1,      n_p1;
    logic signed [15:0]        r_p2,      n_p2;
    logic signed [FRAME_W-1:0] r_res,     n_res;
    logic                      r_rclip,   n_rclip;
    logic signed [FRAME_W-1:0] r_mix_out, n_mix_out;
    logic                      r_clip,    n_clip;
    logic                      r_bend_out, n_bend_out;

    logic              w_accept;
    logic              w_out_free;
    logic              w_we;
    logic              w_re;
    logic [BYTE_W-1:0] w_rdata;

    // effective speed and length
    logic [SPEED_W-1:0] w_ss;
    logic [CW-1:0]      w_len_c;
    logic [DVW-1:0]     w_len;

    // scaling datapath
    logic signed [7:0]  w_c;
    logic signed [17:0] w_p1;
    logic signed [17:0] w_p1_adj;
    logic signed [8:0]  w_v1;
    logic signed [15:0] w_p2;
    logic signed [15:0] w_p2_adj;
    logic signed [7:0]  w_v2;
    logic signed [8:0]  w_sum;

    // position advance
    logic [NW-1:0] w_t;
    logic [MW-1:0] w_t_m;
    logic [MW-1:0] w_len_m;
    logic [MW-1:0] w_wrap1;

    // shared divider
    logic           w_div_start;
    logic [NW-1:0]  w_div_num;
    logic [DVW-1:0] w_div_den;
    logic           w_div_done;
    logic [NW-1:0]  w_div_quo;
    logic [DVW-1:0] w_div_rem;

    psm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // loads beyond the store drop the write but still rewind
    assign w_we = w_accept && (i_in.command == CMD_LOAD)
               && (XW'(i_in.load_index) < XW'(SAMPLE_DEPTH));
    assign w_re = w_accept && (i_in.command == CMD_MIX);

    psm_store #(
        .DEPTH (SAMPLE_DEPTH),
        .AW    (PW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (PW'(i_in.load_index)),
        .i_wdata (i_in.sample_byte),
        .i_re    (w_re),
        .i_raddr (r_pos),
        .o_rdata (w_rdata)
    );

    // zero speed or length count as one; length is capped at the store depth
    assign w_ss    = (w_cfg.sample_speed == '0) ? SPEED_W'(1) : w_cfg.sample_speed;
    assign w_len_c = (w_cfg.sample_length == '0) ? CW'(1)
                   : (CW'(w_cfg.sample_length) > CW'(SAMPLE_DEPTH)) ? CW'(SAMPLE_DEPTH)
                   : CW'(w_cfg.sample_length);
    assign w_len   = DVW'(w_len_c);

    // sample centered around 128: flipping the top bit gives byte - 128
    assign w_c  = $signed({~w_rdata[7], w_rdata[6:0]});
    assign w_p1 = $signed({{10{w_c[7]}}, w_c}) * $signed({9'd0, w_cfg.volume});

    // divide by 256 truncating toward zero
    assign w_p1_adj = r_p1[17] ? (r_p1 + 18'sd255) : r_p1;
    assign w_v1     = w_p1_adj[16:8];
    assign w_p2     = $signed({{7{w_v1[8]}}, w_v1}) * SCALE_NUM;
    assign w_p2_adj = r_p2[15] ? (r_p2 + 16'sd255) : r_p2;
    assign w_v2     = w_p2_adj[15:8];
    assign w_sum    = $signed({r_mix[7], r_mix}) + $signed({w_v2[7], w_v2});

    // new position before wrapping
    assign w_t     = NW'(r_pos) + NW'(r_k);
    assign w_t_m   = MW'(w_t);
    assign w_len_m = MW'(w_len);
    assign w_wrap1 = w_t_m - w_len_m;

    // divider serves the phase step and the position wrap
    assign w_div_num = (r_state == S_POS) ? w_t : NW'(r_num - K_W'(1));
    assign w_div_den = (r_state == S_POS) ? w_len : DVW'(w_ss);

    psm_div #(
        .NW (NW),
        .DW (DVW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_present   = r_present;
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_ovalid    = r_ovalid;
        n_num       = r_num;
        n_k         = r_k;
        n_mix       = r_mix;
        n_bend      = r_bend;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_res       = r_res;
        n_rclip     = r_rclip;
        n_mix_out   = r_mix_out;
        n_clip      = r_clip;
        n_bend_out  = r_bend_out;
        w_div_start = 1'b0;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.command == CMD_LOAD) begin
                        n_present = 1'b1;
                        n_pos     = '0;
                    end else begin
                        n_mix  = i_in.mix_in;
                        n_bend = i_in.block_end;
                        if (r_present) begin
                            n_num   = K_W'(r_acc) + K_W'(w_cfg.current_speed);
                            n_state = S_MUL1;
                        end else begin
                            // nothing loaded yet: frame passes through
                            n_res   = i_in.mix_in;
                            n_rclip = 1'b0;
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_MUL1: begin
                n_p1    = w_p1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_p2    = w_p2;
                n_state = S_ACC;
            end
            S_ACC: begin
                if (w_sum[8] != w_sum[7]) begin
                    n_res   = w_sum[8] ? SAT_MIN : SAT_MAX;
                    n_rclip = 1'b1;
                end else begin
                    n_res   = w_sum[7:0];
                    n_rclip = 1'b0;
                end
                if (r_num > K_W'(w_ss)) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIVK;
                end else begin
                    n_acc   = r_num[ACC_W-1:0];
                    n_k     = '0;
                    n_state = S_POS;
                end
            end
            S_DIVK: begin
                if (w_div_done) begin
                    n_k     = w_div_quo[K_W-1:0];
                    n_acc   = ACC_W'(w_div_rem) + ACC_W'(1);
                    n_state = S_POS;
                end
            end
            S_POS: begin
                if (w_t_m < w_len_m) begin
                    n_pos   = PW'(w_t);
                    n_state = S_DONE;
                end else if (w_wrap1 < w_len_m) begin
                    n_pos   = PW'(w_wrap1);
                    n_state = S_DONE;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_DIVP;
                end
            end
            S_DIVP: begin
                if (w_div_done) begin
                    n_pos   = PW'(w_div_rem);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_ovalid   = 1'b1;
                    n_mix_out  = r_res;
                    n_clip     = r_rclip;
                    n_bend_out = r_bend;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_present <= 1'b0;
            r_pos     <= '0;
            r_acc     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_present <= n_present;
            r_pos     <= n_pos;
            r_acc     <= n_acc;
            r_ovalid  <= n_ovalid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_num      <= n_num;
        r_k        <= n_k;
        r_mix      <= n_mix;
        r_bend     <= n_bend;
        r_p1       <= n_p1;
        r_p2       <= n_p2;
        r_res      <= n_res;
        r_rclip    <= n_rclip;
        r_mix_out  <= n_mix_out;
        r_clip     <= n_clip;
        r_bend_out <= n_bend_out;
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.mix_out       = r_mix_out;
    assign o_out.clipped       = r_clip;
    assign o_out.block_end_out = r_bend_out;

endmodule

// ----- bench/pitched_sample_mixer_top_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench: directed and random load/mix beats against a shadow model
module pitched_sample_mixer_top_tb;
    import psm_pkg::*;

    localparam int STORE_DEPTH   = 4096;
    localparam int SETTLE_CYCLES = 64;
    localparam int TARGET_BEATS  = 1850;
    localparam int FILL_BUDGET   = 64;    // most store entries a random setting may need
    localparam int SAMPLE_CENTER = 128;
    localparam int GAIN_DEN      = 256;
    localparam int FRAME_MAX     = 127;
    localparam int FRAME_MIN     = -128;

    // register settings at the edges of their ranges: sample speed, current
    // speed, volume, length; zero speed, zero length and oversize length included
    localparam int unsigned EDGE_CFG [6][4] = '{
        '{0,     1,     511, 0},
        '{65535, 65535, 0,   1},
        '{65535, 1,     256, 8191},
        '{1,     0,     511, 3},
        '{65535, 0,     128, 4096},
        '{0,     65535, 0,   37}
    };

    typedef struct {
        logic                      command;
        logic [IDX_W-1:0]          load_index;
        logic [BYTE_W-1:0]         sample_byte;
        logic signed [FRAME_W-1:0] mix_in;
        logic                      block_end;
    } t_mixer_beat;

    typedef struct {
        logic signed [FRAME_W-1:0] mix_out;
        logic                      clipped;
        logic                      block_end_out;
    } t_mixed_frame;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    psm_in_if  beat_in ();
    psm_out_if frame_out ();

    pitched_sample_mixer_top #(.SAMPLE_DEPTH(STORE_DEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (beat_in),
        .o_out   (frame_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the mixer state, advanced on every accepted beat
    logic [BYTE_W-1:0] shadow_store [STORE_DEPTH];
    int unsigned       play_pos      = 0;
    int unsigned       phase_acc     = 0;
    bit                sample_loaded = 1'b0;
    t_cfg              mixer_cfg;

    // stimulus bookkeeping: which store entries have a load queued
    bit                store_written [STORE_DEPTH];

    t_mixer_beat  pending_beats [$];
    t_mixed_frame expected_frames [$];
    t_mixer_beat  beat_on_bus;
    t_mixed_frame predicted;
    t_mixed_frame oldest_frame;

    int unsigned beats_queued       = 0;
    int unsigned beats_accepted     = 0;
    int unsigned loads_queued       = 0;
    int unsigned frames_checked     = 0;
    int unsigned clipped_frames     = 0;
    int unsigned settings_count     = 0;
    int unsigned mismatch_count     = 0;
    int unsigned sender_idle_pct    = 34;
    int unsigned receiver_stall_pct = 73;

    // block end marks: mostly regular blocks, now and then a stray mark
    int unsigned block_len  = 2;
    int unsigned block_fill = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one beat through the mixer; returns 1 when the beat yields a frame
    function automatic bit mixer_step(input t_mixer_beat b, output t_mixed_frame f);
        int          scaled;
        int          total;
        int unsigned ss_eff;
        int unsigned len_eff;
        int unsigned steps;
        f.mix_out       = b.mix_in;
        f.clipped       = 1'b0;
        f.block_end_out = b.block_end;
        if (b.command == CMD_LOAD) begin
            shadow_store[b.load_index] = b.sample_byte;
            sample_loaded = 1'b1;
            play_pos      = 0;
            return 1'b0;
        end
        // nothing loaded yet: the frame passes through, position frozen
        if (!sample_loaded) begin
            return 1'b1;
        end
        scaled = int'(shadow_store[play_pos % STORE_DEPTH]) - SAMPLE_CENTER;
        scaled = (scaled * int'(mixer_cfg.volume)) / GAIN_DEN;
        scaled = (scaled * int'(SCALE_NUM)) / GAIN_DEN;
        total  = int'(b.mix_in) + scaled;
        if (total > FRAME_MAX) begin
            total     = FRAME_MAX;
            f.clipped = 1'b1;
        end else if (total < FRAME_MIN) begin
            total     = FRAME_MIN;
            f.clipped = 1'b1;
        end
        f.mix_out = total[FRAME_W-1:0];
        // zero speed and zero length act as one, oversize length as the depth
        ss_eff  = (mixer_cfg.sample_speed == 0) ? 1 : mixer_cfg.sample_speed;
        len_eff = (mixer_cfg.sample_length == 0) ? 1 : mixer_cfg.sample_length;
        if (len_eff > STORE_DEPTH) begin
            len_eff = STORE_DEPTH;
        end
        phase_acc += mixer_cfg.current_speed;
        if (phase_acc > ss_eff) begin
            steps      = (phase_acc - 1) / ss_eff;
            phase_acc -= steps * ss_eff;
            play_pos  += steps;
        end
        phase_acc &= (1 << ACC_W) - 1;
        // a stale position past a shortened length wraps only here
        play_pos %= len_eff;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        $display("[%0t] frame %0d: %s is %0d, predicted %0d",
                 $time, frames_checked, field, got, want);
    endtask

    // driver: a new beat goes out only when the bus is free or the last one was taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            beat_in.valid <= 1'b0;
        end else begin
            if (beat_in.valid && beat_in.ready) begin
                beats_accepted++;
                if (mixer_step(beat_on_bus, predicted)) begin
                    expected_frames.push_back(predicted);
                end
            end
            if (!beat_in.valid || beat_in.ready) begin
                if (pending_beats.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
                    beat_on_bus = pending_beats.pop_front();
                    beat_in.valid       <= 1'b1;
                    beat_in.command     <= beat_on_bus.command;
                    beat_in.load_index  <= beat_on_bus.load_index;
                    beat_in.sample_byte <= beat_on_bus.sample_byte;
                    beat_in.mix_in      <= beat_on_bus.mix_in;
                    beat_in.block_end   <= beat_on_bus.block_end;
                end else begin
                    beat_in.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: every output beat is matched against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_out.ready <= 1'b0;
        end else begin
            if (frame_out.valid && frame_out.ready) begin
                if (expected_frames.size() == 0) begin
                    report_mismatch("unpredicted frame, mix_out", int'(frame_out.mix_out), 0);
                end else begin
                    oldest_frame = expected_frames.pop_front();
                    if (frame_out.mix_out !== oldest_frame.mix_out) begin
                        report_mismatch("mix_out", int'(frame_out.mix_out),
                                        int'(oldest_frame.mix_out));
                    end
                    if (frame_out.clipped !== oldest_frame.clipped) begin
                        report_mismatch("clipped", int'(frame_out.clipped),
                                        int'(oldest_frame.clipped));
                    end
                    if (frame_out.block_end_out !== oldest_frame.block_end_out) begin
                        report_mismatch("block_end_out", int'(frame_out.block_end_out),
                                        int'(oldest_frame.block_end_out));
                    end
                end
                if (frame_out.clipped === 1'b1) begin
                    clipped_frames++;
                end
                frames_checked++;
            end
            frame_out.ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
        end
    end

    task automatic reg_write(input logic [1:0] idx, input int unsigned value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SAMPLE_SPEED:  mixer_cfg.sample_speed  = value[SPEED_W-1:0];
            REG_CURRENT_SPEED: mixer_cfg.current_speed = value[SPEED_W-1:0];
            REG_VOLUME:        mixer_cfg.volume        = value[VOL_W-1:0];
            REG_SAMPLE_LENGTH: mixer_cfg.sample_length = value[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // hold the sender until every beat is taken and every frame is back
    task automatic wait_quiet();
        while (beats_accepted != beats_queued || expected_frames.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_load(input int unsigned idx, input logic [BYTE_W-1:0] value);
        t_mixer_beat b;
        b.command     = CMD_LOAD;
        b.load_index  = idx[IDX_W-1:0];
        b.sample_byte = value;
        b.mix_in      = FRAME_W'($urandom());
        b.block_end   = 1'($urandom_range(1, 0));
        store_written[idx[IDX_W-1:0]] = 1'b1;
        pending_beats.push_back(b);
        beats_queued++;
        loads_queued++;
    endtask

    task automatic queue_mix(input logic signed [FRAME_W-1:0] frame);
        t_mixer_beat b;
        b.command     = CMD_MIX;
        b.load_index  = IDX_W'($urandom());     // ignored on a mix
        b.sample_byte = BYTE_W'($urandom());
        b.mix_in      = frame;
        if (block_fill + 1 >= block_len) begin
            b.block_end = 1'b1;
            block_fill  = 0;
            block_len   = $urandom_range(16, 1);
        end else begin
            b.block_end = ($urandom_range(29, 0) == 0);
            block_fill++;
        end
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    // store entries [0, extent) cover every read of a phase of n mixes:
    // the total advance is bounded by (acc + n * speed) / sample speed
    function automatic int unsigned read_extent(input int unsigned ss, input int unsigned cs,
                                                input int unsigned len, input int unsigned n);
        longint unsigned ss_eff;
        longint unsigned len_eff;
        longint unsigned reach;
        ss_eff  = (ss == 0) ? 1 : ss;
        len_eff = (len == 0) ? 1 : ((len > STORE_DEPTH) ? STORE_DEPTH : len);
        reach   = play_pos + (phase_acc + longint'(n) * cs) / ss_eff + 1;
        return 32'((reach < len_eff) ? reach : len_eff);
    endfunction

    // program all registers, then fill what the phase will read, then play
    task automatic program_and_play(input int unsigned ss, input int unsigned cs,
                                    input int unsigned vol, input int unsigned len,
                                    input int unsigned n_mix);
        int unsigned extent;
        int unsigned mixes;
        reg_write(REG_SAMPLE_SPEED, ss);
        reg_write(REG_CURRENT_SPEED, cs);
        reg_write(REG_VOLUME, vol);
        reg_write(REG_SAMPLE_LENGTH, len);
        settings_count++;
        extent = read_extent(ss, cs, len, n_mix);
        for (int unsigned i = 0; i < extent; i++) begin
            if (!store_written[i]) begin
                queue_load(i, BYTE_W'($urandom()));
            end
        end
        if (!store_written[play_pos % STORE_DEPTH]) begin
            queue_load(play_pos % STORE_DEPTH, BYTE_W'($urandom()));
        end
        mixes = 0;
        while (mixes < n_mix) begin
            // stray loads anywhere in the store rewind the position
            if ($urandom_range(99, 0) < 12) begin
                queue_load($urandom_range(STORE_DEPTH - 1, 0), BYTE_W'($urandom()));
            end else begin
                case ($urandom_range(9, 0))
                    0:       queue_mix(8'sh7f);
                    1:       queue_mix(8'sh80);
                    default: queue_mix(FRAME_W'($urandom()));
                endcase
                mixes++;
            end
        end
    endtask

    function automatic int unsigned pick_speed();
        case ($urandom_range(5, 0))
            0:       return 0;
            1:       return 65535;
            2, 3:    return $urandom_range(8, 1);
            default: return $urandom_range(65535, 0);
        endcase
    endfunction

    initial begin
        int unsigned ss;
        int unsigned cs;
        int unsigned vol;
        int unsigned len;
        int unsigned n_mix;
        int unsigned tries;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        beat_in.valid       = 1'b0;
        beat_in.command     = CMD_LOAD;
        beat_in.load_index  = '0;
        beat_in.sample_byte = '0;
        beat_in.mix_in      = '0;
        beat_in.block_end   = 1'b0;
        frame_out.ready     = 1'b0;
        mixer_cfg.sample_speed  = RST_SAMPLE_SPEED;
        mixer_cfg.current_speed = RST_CURRENT_SPEED;
        mixer_cfg.volume        = RST_VOLUME;
        mixer_cfg.sample_length = RST_SAMPLE_LENGTH;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // nothing loaded yet: frames pass through untouched
        queue_mix(8'sh7f);
        queue_mix(8'sh80);
        queue_mix(8'sh00);
        queue_mix(8'shff);

        // reset registers, a short sample with both extremes, silence and the
        // values next to it; at unit pitch it reads 0, 0, 1, 2 ... 6
        queue_load(STORE_DEPTH - 1, 8'h5a);
        queue_load(0, 8'hff);
        queue_load(1, 8'h00);
        queue_load(2, 8'h7f);
        queue_load(3, 8'h80);
        queue_load(4, 8'hff);
        queue_load(5, 8'h00);
        queue_load(6, 8'h81);
        queue_mix(8'sh7f);        // full scale sample on a full scale frame clips high
        queue_mix(8'sh00);
        queue_mix(8'sh80);        // lowest sample on the lowest frame clips low
        queue_mix(-8'sd1);        // -1 centered truncates to 0
        queue_mix(8'sh7f);
        queue_mix(8'sh80);
        queue_mix(8'sd100);
        queue_mix(-8'sd100);

        // register extremes, each phase after the previous one has drained
        for (int i = 0; i < 6; i++) begin
            wait_quiet();
            program_and_play(EDGE_CFG[i][0], EDGE_CFG[i][1], EDGE_CFG[i][2], EDGE_CFG[i][3],
                             $urandom_range(40, 20));
        end

        // random settings; the first third mostly with receiver stalls, the second mostly
        // with sender gaps, the last with a free-running bus
        while (beats_queued < TARGET_BEATS) begin
            wait_quiet();
            if (beats_queued >= 2 * TARGET_BEATS / 3) begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end else if (beats_queued >= TARGET_BEATS / 3) begin
                sender_idle_pct    = 73;
                receiver_stall_pct = 34;
            end
            n_mix = $urandom_range(60, 15);
            tries = 0;
            do begin
                ss = pick_speed();
                cs = pick_speed();
                case ($urandom_range(5, 0))
                    0:       vol = 0;
                    1:       vol = 256;
                    2:       vol = 511;
                    3:       vol = $urandom_range(511, 257);
                    default: vol = $urandom_range(256, 0);
                endcase
                case ($urandom_range(9, 0))
                    0:       len = 0;
                    1:       len = 1;
                    2:       len = STORE_DEPTH;
                    3:       len = 8191;
                    4:       len = $urandom_range(8191, 0);
                    default: len = $urandom_range(40, 1);
                endcase
                tries++;
            end while (read_extent(ss, cs, len, n_mix) > FILL_BUDGET && tries < 16);
            // fast pitch over a long sample would need too much of the store
            if (read_extent(ss, cs, len, n_mix) > FILL_BUDGET) begin
                len = $urandom_range(16, 1);
            end
            program_and_play(ss, cs, vol, len, n_mix);
        end

        wait_quiet();
        $display("run covered %0d beats (%0d loads) under %0d register settings",
                 beats_accepted, loads_queued, settings_count);
        $display("compared %0d mixed frames, %0d of them saturated, %0d mismatches",
                 frames_checked, clipped_frames, mismatch_count);
        if (mismatch_count == 0 && expected_frames.size() == 0) begin
            $display("pitched_sample_mixer_top regression: pass");
        end else begin
            $display("pitched_sample_mixer_top regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("timeout: %0d of %0d beats taken, %0d frames outstanding",
                 beats_accepted, beats_queued, expected_frames.size());
        $display("pitched_sample_mixer_top regression: fail");
        $finish;
    end

endmodule
